// ===== hw/rtl/zca_pkg.sv =====
// Shared types, constants and codes of the zoom crop address generator.
// No dependencies; every other file imports this package.
package zca_pkg;

  localparam int DIM_BITS    = 13;
  localparam int ADDR_BITS   = 32;
  localparam int FMT_BITS    = 4;
  localparam int ZOOM_BITS   = 12;
  localparam int PITCH_BITS  = 16;
  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 8;

  // Divider: quotient bits resolved per pipeline step
  localparam int DIV_BITS_PER_STEP = 4;
  localparam int DIV_STEPS = (DIM_BITS + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
  localparam int STEP_BITS = $clog2(DIV_STEPS);
  localparam int REM_BITS  = DIM_BITS + FRAC_BITS;
  localparam int CMP_BITS  = DIM_BITS + ZOOM_BITS;

  localparam logic [ZOOM_BITS-1:0] ZOOM_MIN = ZOOM_BITS'(12'h100);
  localparam logic [ZOOM_BITS-1:0] ZOOM_MAX = ZOOM_BITS'(12'h400);

  localparam logic [FMT_BITS-1:0] FMT_PACKED_FIRST = 4'd0;
  localparam logic [FMT_BITS-1:0] FMT_PACKED_LAST  = 4'd3;
  localparam logic [FMT_BITS-1:0] FMT_NV12         = 4'd4;
  localparam logic [FMT_BITS-1:0] FMT_NV21         = 4'd5;
  localparam logic [FMT_BITS-1:0] FMT_I420         = 4'd6;
  localparam logic [FMT_BITS-1:0] FMT_YV12         = 4'd7;
  localparam logic [FMT_BITS-1:0] FMT_ARGB32       = 4'd8;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ZOOM = 3'd1,
    ST_GEOM = 3'd2,
    ST_FMT  = 3'd3,
    ST_NULL = 3'd4
  } status_e;

  typedef struct packed {
    logic [FMT_BITS-1:0]  fmt_code;
    logic [DIM_BITS-1:0]  src_width;
    logic [DIM_BITS-1:0]  src_height;
    logic [DIM_BITS-1:0]  src_stride;
    logic [ZOOM_BITS-1:0] zoom_q8;
    logic [WORD_BITS-1:0] base_y;
    logic [WORD_BITS-1:0] base_u;
    logic [WORD_BITS-1:0] base_v;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [DIM_BITS-1:0]   crop_w;
    logic [DIM_BITS-1:0]   crop_h;
    logic [WORD_BITS-1:0]  crop_x;
    logic [WORD_BITS-1:0]  crop_y;
    logic [PITCH_BITS-1:0] src_pitch;
    logic [ADDR_BITS-1:0]  read_y;
    logic [ADDR_BITS-1:0]  read_u;
    logic [ADDR_BITS-1:0]  read_v;
  } out_t;

  typedef struct packed {
    in_t     desc;
    status_e status;
  } job_t;

  typedef struct packed {
    logic [REM_BITS-1:0] rem_w;
    logic [REM_BITS-1:0] rem_h;
    logic [DIM_BITS-1:0] quo_w;
    logic [DIM_BITS-1:0] quo_h;
  } div_t;

  typedef struct packed {
    job_t                 job;
    logic [DIM_BITS:0]    crop_w;
    logic [DIM_BITS:0]    crop_h;
    logic [WORD_BITS-1:0] crop_x;
    logic [WORD_BITS-1:0] crop_y;
  } crop_t;

endpackage

// ===== hw/rtl/zca_if.sv =====
// Valid/ready channel interfaces for descriptor and result words.
// Depends on zca_pkg.
interface zca_in_if import zca_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface zca_out_if import zca_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/zca_check.sv =====
// First stage: descriptor checks and divider seed.
// Depends on zca_pkg.
module zca_check import zca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  desc_i,
  output logic valid_o,
  input  logic ready_i,
  output job_t job_o,
  output div_t div_o
);

  logic    valid_q;
  job_t    job_q;
  div_t    div_q;
  status_e status_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    status_d = ST_OK;
    if (desc_i.zoom_q8 < ZOOM_MIN || desc_i.zoom_q8 > ZOOM_MAX) begin
      status_d = ST_ZOOM;
    end else if (desc_i.src_width == '0 || desc_i.src_height == '0 ||
                 desc_i.src_stride < desc_i.src_width) begin
      status_d = ST_GEOM;
    end else if (desc_i.fmt_code inside {[FMT_PACKED_FIRST:FMT_PACKED_LAST]}) begin
      if (desc_i.base_y == '0) status_d = ST_NULL;
    end else if (desc_i.fmt_code inside {FMT_NV12, FMT_NV21}) begin
      if (desc_i.base_y == '0 || desc_i.base_u == '0) status_d = ST_NULL;
    end else if (desc_i.fmt_code inside {FMT_I420, FMT_YV12}) begin
      if (desc_i.base_y == '0 || desc_i.base_u == '0 || desc_i.base_v == '0) begin
        status_d = ST_NULL;
      end
    end else if (desc_i.fmt_code == FMT_ARGB32) begin
      status_d = (desc_i.base_y == '0) ? ST_NULL : ST_FMT;
    end else begin
      status_d = ST_FMT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      job_q.desc   <= desc_i;
      job_q.status <= status_d;
      div_q.rem_w  <= {desc_i.src_width, FRAC_BITS'(0)};
      div_q.rem_h  <= {desc_i.src_height, FRAC_BITS'(0)};
      div_q.quo_w  <= '0;
      div_q.quo_h  <= '0;
    end
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;
  assign div_o   = div_q;

endmodule

// ===== hw/rtl/zca_div_step.sv =====
// One step of the pipelined restoring divider: size * 256 / zoom for
// width and height in parallel. Depends on zca_pkg.
module zca_div_step import zca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [STEP_BITS-1:0] step_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  job_t                 job_i,
  input  div_t                 div_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output job_t                 job_o,
  output div_t                 div_o
);

  logic valid_q;
  job_t job_q;
  div_t div_q;
  div_t div_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    int                  idx;
    logic [CMP_BITS-1:0] dsh;
    logic [CMP_BITS-1:0] rw;
    logic [CMP_BITS-1:0] rh;
    rw    = CMP_BITS'(div_i.rem_w);
    rh    = CMP_BITS'(div_i.rem_h);
    div_d = div_i;
    for (int b = 0; b < DIV_BITS_PER_STEP; b++) begin
      idx = DIM_BITS - 1 - (int'(step_i) * DIV_BITS_PER_STEP + b);
      dsh = '0;
      if (idx >= 0) begin
        dsh = CMP_BITS'(job_i.desc.zoom_q8) << idx;
        // subtract the shifted divisor where it fits; set that quotient bit
        if (rw >= dsh) begin
          rw          = rw - dsh;
          div_d.quo_w = div_d.quo_w | (DIM_BITS'(1) << idx);
        end
        if (rh >= dsh) begin
          rh          = rh - dsh;
          div_d.quo_h = div_d.quo_h | (DIM_BITS'(1) << idx);
        end
      end
    end
    div_d.rem_w = rw[REM_BITS-1:0];
    div_d.rem_h = rh[REM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      job_q <= job_i;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;
  assign div_o   = div_q;

endmodule

// ===== hw/rtl/zca_crop.sv =====
// Crop window stage: align the quotients, form the centred start offsets.
// Depends on zca_pkg.
module zca_crop import zca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  job_t  job_i,
  input  div_t  div_i,
  output logic  valid_o,
  input  logic  ready_i,
  output crop_t crop_o
);

  logic  valid_q;
  crop_t crop_q;
  crop_t crop_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic [WORD_BITS-1:0] cw;
    logic [WORD_BITS-1:0] ch;
    logic [WORD_BITS-1:0] dx;
    logic [WORD_BITS-1:0] dy;
    cw = (WORD_BITS'(div_i.quo_w) + WORD_BITS'(3)) & ~WORD_BITS'(3);
    ch = (WORD_BITS'(div_i.quo_h) + WORD_BITS'(1)) & ~WORD_BITS'(1);
    // wraps when the aligned crop exceeds the source
    dx = (WORD_BITS'(job_i.desc.src_width) - cw) >> 1;
    dy = (WORD_BITS'(job_i.desc.src_height) - ch) >> 1;
    crop_d.job    = job_i;
    crop_d.crop_w = cw[DIM_BITS:0];
    crop_d.crop_h = ch[DIM_BITS:0];
    crop_d.crop_x = (dx + WORD_BITS'(3)) & ~WORD_BITS'(3);
    crop_d.crop_y = (dy + WORD_BITS'(1)) & ~WORD_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) crop_q <= crop_d;
  end

  assign valid_o = valid_q;
  assign crop_o  = crop_q;

endmodule

// ===== hw/rtl/zca_addr.sv =====
// Address stages: row products, then per-plane origin sums into the
// result register. Depends on zca_pkg.
module zca_addr import zca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  crop_t crop_i,
  output logic  valid_o,
  input  logic  ready_i,
  output out_t  res_o
);

  logic                 mul_valid_q;
  crop_t                mul_crop_q;
  logic [DIM_BITS:0]    pitch_q;
  logic [WORD_BITS-1:0] prod_y_q;
  logic [WORD_BITS-1:0] prod_c_q;
  logic                 mul_ready;
  logic                 res_valid_q;
  out_t                 res_q;
  out_t                 res_d;
  logic                 packed_i;
  logic                 planar_i;
  logic [DIM_BITS:0]    pitch_d;
  logic [DIM_BITS-1:0]  cmul_d;

  assign mul_ready = !res_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  assign packed_i = crop_i.job.desc.fmt_code inside {[FMT_PACKED_FIRST:FMT_PACKED_LAST]};
  assign planar_i = crop_i.job.desc.fmt_code inside {FMT_I420, FMT_YV12};
  assign pitch_d  = packed_i ? {crop_i.job.desc.src_stride, 1'b0}
                             : {1'b0, crop_i.job.desc.src_stride};
  assign cmul_d   = planar_i ? (crop_i.job.desc.src_stride >> 1)
                             : crop_i.job.desc.src_stride;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (ready_o)   mul_valid_q <= valid_i;
      if (mul_ready) res_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mul_crop_q <= crop_i;
      pitch_q    <= pitch_d;
      prod_y_q   <= WORD_BITS'(WORD_BITS'(pitch_d) * crop_i.crop_y);
      prod_c_q   <= WORD_BITS'(WORD_BITS'(cmul_d) * crop_i.crop_y);
    end
  end

  always_comb begin
    logic                 pk;
    logic                 pl;
    logic [WORD_BITS-1:0] offy;
    logic [WORD_BITS-1:0] offc;
    logic [WORD_BITS-1:0] rowc;
    logic [WORD_BITS-1:0] ry;
    logic [WORD_BITS-1:0] ru;
    logic [WORD_BITS-1:0] rv;
    pk   = mul_crop_q.job.desc.fmt_code inside {[FMT_PACKED_FIRST:FMT_PACKED_LAST]};
    pl   = mul_crop_q.job.desc.fmt_code inside {FMT_I420, FMT_YV12};
    offy = pk ? (mul_crop_q.crop_x << 1) : mul_crop_q.crop_x;
    offc = pl ? (mul_crop_q.crop_x >> 1) : mul_crop_q.crop_x;
    rowc = prod_c_q >> 1;
    ry   = mul_crop_q.job.desc.base_y + prod_y_q + offy;
    ru   = pk ? '0 : (mul_crop_q.job.desc.base_u + rowc + offc);
    rv   = pl ? (mul_crop_q.job.desc.base_v + rowc + offc) : '0;
    res_d = '0;
    res_d.status = mul_crop_q.job.status;
    // any failed check zeroes the rest of the word
    if (mul_crop_q.job.status == ST_OK) begin
      res_d.crop_w    = mul_crop_q.crop_w[DIM_BITS-1:0];
      res_d.crop_h    = mul_crop_q.crop_h[DIM_BITS-1:0];
      res_d.crop_x    = mul_crop_q.crop_x;
      res_d.crop_y    = mul_crop_q.crop_y;
      res_d.src_pitch = PITCH_BITS'(pitch_q);
      res_d.read_y    = ry[ADDR_BITS-1:0];
      res_d.read_u    = ru[ADDR_BITS-1:0];
      res_d.read_v    = rv[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && mul_valid_q) res_q <= res_d;
  end

  assign valid_o = res_valid_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/zoom_crop_address_gen.sv =====
// Zoom crop address generator: a descriptor word passes the check stage, the
// divider steps, the crop stage, the product stage and the result register.
// Throughput one word per cycle while the result channel does not stall; the divider pipeline resolves 4 quotient
// bits per stage and every stage holds its word under backpressure.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload
// registers are not reset. Depends on zca_pkg, zca_if and the zca_* stages.
module zoom_crop_address_gen import zca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  zca_in_if.sink    job_i,
  zca_out_if.source res_o
);

  // Stage chain: check -> divider steps -> crop -> products -> result.
  logic valid_s [DIV_STEPS+1];
  logic ready_s [DIV_STEPS+1];
  job_t job_s   [DIV_STEPS+1];
  div_t div_s   [DIV_STEPS+1];

  logic  crop_valid;
  logic  crop_ready;
  crop_t crop_w;

  // Check stage: status codes and divider seed (size shifted by 8)
  zca_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_i.valid),
    .ready_o (job_i.ready),
    .desc_i  (job_i.payload),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .job_o   (job_s[0]),
    .div_o   (div_s[0])
  );

  // Divider: one step per stage, most significant quotient bits first
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    zca_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_BITS'(g)),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .job_i   (job_s[g]),
      .div_i   (div_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .job_o   (job_s[g+1]),
      .div_o   (div_s[g+1])
    );
  end

  // Align the window and center it
  zca_crop u_crop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[DIV_STEPS]),
    .ready_o (ready_s[DIV_STEPS]),
    .job_i   (job_s[DIV_STEPS]),
    .div_i   (div_s[DIV_STEPS]),
    .valid_o (crop_valid),
    .ready_i (crop_ready),
    .crop_o  (crop_w)
  );

  // Row products, then plane addresses into the result register
  zca_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (crop_valid),
    .ready_o (crop_ready),
    .crop_i  (crop_w),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_o.payload)
  );

endmodule

// ===== hw/rtl/zca_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
// Depends on zca_pkg and zoom_crop_address_gen.
module zca_checker import zca_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_payload_i
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result word changed");

  // Failed check zeroes the sizes, pitch and read addresses of the result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.status != ST_OK |->
      out_payload_i.crop_w == '0 && out_payload_i.crop_h == '0 &&
      out_payload_i.src_pitch == '0 && out_payload_i.read_y == '0 &&
      out_payload_i.read_u == '0 && out_payload_i.read_v == '0)
    else $error("error result carries data");

  // Good window is aligned
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.status == ST_OK |->
      out_payload_i.crop_w[1:0] == 2'b00 && out_payload_i.crop_h[0] == 1'b0 &&
      out_payload_i.crop_x[1:0] == 2'b00 && out_payload_i.crop_y[0] == 1'b0)
    else $error("crop window misaligned");

  // No result word right after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind zoom_crop_address_gen zca_checker u_zca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);

// ===== tb/tb_zoom_crop_address_gen.sv =====
// Testbench for the zoom crop address generator: drives descriptor words,
// predicts each result word and checks it. Depends on zca_pkg, zca_if and zoom_crop_address_gen.
`timescale 1ns / 1ps

module tb_zoom_crop_address_gen;
  import zca_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  zca_in_if  job_if ();
  zca_out_if res_if ();

  zoom_crop_address_gen i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if.sink),
    .res_o  (res_if.source)
  );

  // Expected result words, oldest first.
  out_t   crop_expected_q[$];
  int     mismatch_cnt = 0;
  logic   rx_stall_en  = 1'b1;
  int     burst_left   = 0;

  // Align value up to a power-of-two boundary.
  function automatic logic [31:0] align_up(logic [31:0] v, logic [31:0] a);
    return (v + (a - 1)) & ~(a - 1);
  endfunction

  // Predict the result word for one descriptor.
  function automatic out_t predict_crop(in_t d);
    out_t        r;
    logic [31:0] w, h, s, z, cw, ch, cx, cy, pitch, cp, half;
    status_e     st;
    r = '0;
    w = 32'(d.src_width);
    h = 32'(d.src_height);
    s = 32'(d.src_stride);
    z = 32'(d.zoom_q8);
    st = ST_OK;
    if (d.zoom_q8 < ZOOM_MIN || d.zoom_q8 > ZOOM_MAX) st = ST_ZOOM;
    else if (w == 0 || h == 0 || s < w) st = ST_GEOM;
    else if (d.fmt_code <= FMT_PACKED_LAST) begin
      if (d.base_y == 0) st = ST_NULL;
    end else if (d.fmt_code == FMT_NV12 || d.fmt_code == FMT_NV21) begin
      if (d.base_y == 0 || d.base_u == 0) st = ST_NULL;
    end else if (d.fmt_code == FMT_I420 || d.fmt_code == FMT_YV12) begin
      if (d.base_y == 0 || d.base_u == 0 || d.base_v == 0) st = ST_NULL;
    end else if (d.fmt_code == FMT_ARGB32) begin
      st = (d.base_y == 0) ? ST_NULL : ST_FMT;
    end else st = ST_FMT;
    r.status = st;
    if (st != ST_OK) return r;
    cw = align_up((w * 256) / z, 4);
    ch = align_up((h * 256) / z, 2);
    cx = align_up((w - cw) >> 1, 4);
    cy = align_up((h - ch) >> 1, 2);
    r.crop_w = cw[DIM_BITS-1:0];
    r.crop_h = ch[DIM_BITS-1:0];
    r.crop_x = cx;
    r.crop_y = cy;
    if (d.fmt_code <= FMT_PACKED_LAST) begin
      pitch = 2 * s;
      r.read_y = d.base_y + pitch * cy + 2 * cx;
    end else if (d.fmt_code == FMT_NV12 || d.fmt_code == FMT_NV21) begin
      pitch = s;
      half = (s * cy) / 2;
      r.read_y = d.base_y + s * cy + cx;
      r.read_u = d.base_u + half + cx;
    end else begin
      pitch = s;
      cp = s >> 1;
      half = (cp * cy) / 2;
      r.read_y = d.base_y + s * cy + cx;
      r.read_u = d.base_u + half + cx / 2;
      r.read_v = d.base_v + half + cx / 2;
    end
    r.src_pitch = pitch[PITCH_BITS-1:0];
    return r;
  endfunction

  // Send one descriptor word; hold it until accepted. Gaps come between bursts.
  task automatic send_job(in_t d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        job_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    job_if.valid   <= 1'b1;
    job_if.payload <= d;
    do @(posedge clk_i); while (!job_if.ready);
    crop_expected_q.push_back(predict_crop(d));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    job_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (crop_expected_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_t good_job(logic [3:0] fmt);
    in_t d;
    d.fmt_code   = fmt;
    d.src_width  = DIM_BITS'($urandom_range(1, 8191));
    d.src_height = DIM_BITS'($urandom_range(1, 8191));
    d.src_stride = DIM_BITS'($urandom_range(d.src_width, 8191));
    d.zoom_q8    = ZOOM_BITS'($urandom_range(ZOOM_MIN, ZOOM_MAX));
    d.base_y     = $urandom | 32'h1;
    d.base_u     = $urandom | 32'h1;
    d.base_v     = $urandom | 32'h1;
    return d;
  endfunction

  // Extremes of the zoom range, geometry, every format, null bases.
  task automatic test_directed();
    in_t d;
    d = good_job(FMT_NV12); d.zoom_q8 = '0;                send_job(d);
    d = good_job(FMT_NV12); d.zoom_q8 = ZOOM_MIN - ZOOM_BITS'(1); send_job(d);
    d = good_job(FMT_NV12); d.zoom_q8 = ZOOM_MAX + ZOOM_BITS'(1); send_job(d);
    d = good_job(FMT_NV12); d.zoom_q8 = '1;                send_job(d);
    d = good_job(FMT_I420); d.zoom_q8 = ZOOM_MIN;          send_job(d);
    d = good_job(FMT_I420); d.zoom_q8 = ZOOM_MAX;          send_job(d);
    d = good_job(FMT_NV12); d.src_width = '0;              send_job(d);
    d = good_job(FMT_NV12); d.src_height = '0;             send_job(d);
    d = good_job(FMT_NV12); d.src_width = DIM_BITS'(100);
    d.src_stride = DIM_BITS'(99); send_job(d);
    // Full-size source at unit zoom: crop wraps to zero, offsets wrap.
    d = good_job(FMT_PACKED_FIRST); d.src_width = '1; d.src_height = '1;
    d.src_stride = '1;
    d.zoom_q8 = ZOOM_MIN; send_job(d);
    // Tiny source: the aligned crop exceeds the source only when the random zoom is ZOOM_MIN.
    d = good_job(FMT_YV12); d.src_width = DIM_BITS'(1); d.src_height = DIM_BITS'(1);
    d.src_stride = DIM_BITS'(1);
    send_job(d);
    for (int f = 0; f < 16; f++) begin
      d = good_job(4'(f)); send_job(d);
      d = good_job(4'(f)); d.base_y = '0; send_job(d);
    end
    d = good_job(FMT_NV21); d.base_u = '0; send_job(d);
    d = good_job(FMT_I420); d.base_v = '0; send_job(d);
    d = good_job(FMT_ARGB32); d.base_u = '0; d.base_v = '0; send_job(d);
  endtask

  // Mostly well-formed jobs with random content, some noise.
  task automatic test_random(int n);
    in_t d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        d = good_job(4'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0) begin
          d.src_width  = DIM_BITS'($urandom_range(1, 64));
          d.src_height = DIM_BITS'($urandom_range(1, 64));
          d.src_stride = DIM_BITS'($urandom_range(d.src_width, 8191));
        end
      end else begin
        d = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end
      send_job(d);
      if (i == n / 2) wait_drained();  // hold off until all results are in
    end
  endtask

  // Receiver stall pattern; a quiet window runs without stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= rx_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want, got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (crop_expected_q.size() == 0) begin
        $error("unexpected result word, status %0d", got.status);
        mismatch_cnt++;
      end else begin
        want = crop_expected_q.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); mismatch_cnt++;
        end
        if (got.crop_w !== want.crop_w) begin
          $error("crop_w exp %0d got %0d", want.crop_w, got.crop_w); mismatch_cnt++;
        end
        if (got.crop_h !== want.crop_h) begin
          $error("crop_h exp %0d got %0d", want.crop_h, got.crop_h); mismatch_cnt++;
        end
        if (got.crop_x !== want.crop_x) begin
          $error("crop_x exp %h got %h", want.crop_x, got.crop_x); mismatch_cnt++;
        end
        if (got.crop_y !== want.crop_y) begin
          $error("crop_y exp %h got %h", want.crop_y, got.crop_y); mismatch_cnt++;
        end
        if (got.src_pitch !== want.src_pitch) begin
          $error("src_pitch exp %h got %h", want.src_pitch, got.src_pitch);
          mismatch_cnt++;
        end
        if (got.read_y !== want.read_y) begin
          $error("read_y exp %h got %h", want.read_y, got.read_y); mismatch_cnt++;
        end
        if (got.read_u !== want.read_u) begin
          $error("read_u exp %h got %h", want.read_u, got.read_u); mismatch_cnt++;
        end
        if (got.read_v !== want.read_v) begin
          $error("read_v exp %h got %h", want.read_v, got.read_v); mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    job_if.valid   = 1'b0;
    job_if.payload = '0;
    res_if.ready   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    rx_stall_en = 1'b0;
    test_random(100);
    rx_stall_en = 1'b1;
    test_random(400);
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && crop_expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
